### hdl/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared codes, widths and beat types of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int KIND_W = 3;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 7;
  localparam int POS_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] KIND_PAT_SYM    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAT_END    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TEXT_SYM   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TEXT_START = 3'd4;

  localparam logic RES_MATCH    = 1'b0;
  localparam logic RES_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [SYM_W-1:0]  sym;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] end_index;
    logic [LEN_W-1:0] pattern_length;
    logic             last;
  } result_t;

endpackage

### hdl/mpsm_front.sv
// ----------------------------------------------------------------------------
// mpsm_front
// Accepts input beats, drops reserved kinds, folds the symbol into the
// alphabet and queues the resulting commands for the engine.
// ----------------------------------------------------------------------------
module mpsm_front #(
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mpsm_pkg::KIND_W-1:0] kind,
  input  logic [mpsm_pkg::SYM_W-1:0]  symbol,
  output logic                        cmd_valid,
  input  logic                        cmd_pop,
  output mpsm_pkg::cmd_t              cmd
);
  import mpsm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [SYM_W-1:0] sym_mod [256];
  cmd_t             slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             enq;
  logic             deq;

  for (genvar i = 0; i < 256; i++) begin : g_sym
    assign sym_mod[i] = SYM_W'(i % ALPHABET_SIZE);
  end

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign enq       = push && !full && (kind <= KIND_TEXT_START);
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= '{op: kind, sym: sym_mod[symbol]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(enq) - (PW+1)'(deq);
    end
  end

endmodule

### hdl/mpsm_engine.sv
// ----------------------------------------------------------------------------
// mpsm_engine
// Sequencer that owns the trie and link tables: inserts pattern symbols,
// builds failure and output links breadth-first and walks text symbols.
// ----------------------------------------------------------------------------
module mpsm_engine #(
  parameter int NODE_COUNT         = 256,
  parameter int ALPHABET_SIZE      = 256,
  parameter int MAX_PATTERN_LENGTH = 64,
  parameter int POSITION_BITS      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  mpsm_pkg::cmd_t    cmd,
  input  logic              res_full,
  output logic              res_push,
  output mpsm_pkg::result_t res
);
  import mpsm_pkg::*;

  localparam int NB = $clog2(NODE_COUNT);
  localparam int SB = $clog2(ALPHABET_SIZE);
  localparam int CW = NB + SB;
  localparam int CHILD_DEPTH = 1 << CW;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_PS_CHK = 5'd2;
  localparam logic [4:0] S_OVF    = 5'd3;
  localparam logic [4:0] S_TF_RD  = 5'd4;
  localparam logic [4:0] S_TF_CHK = 5'd5;
  localparam logic [4:0] S_TO_RD  = 5'd6;
  localparam logic [4:0] S_TO_CHK = 5'd7;
  localparam logic [4:0] S_BR_RD  = 5'd8;
  localparam logic [4:0] S_BR_CHK = 5'd9;
  localparam logic [4:0] S_BP     = 5'd10;
  localparam logic [4:0] S_BP2    = 5'd11;
  localparam logic [4:0] S_BCUR   = 5'd12;
  localparam logic [4:0] S_BS_RD  = 5'd13;
  localparam logic [4:0] S_BS_CHK = 5'd14;
  localparam logic [4:0] S_BF_RD  = 5'd15;
  localparam logic [4:0] S_BF_CHK = 5'd16;
  localparam logic [4:0] S_BT_RD  = 5'd17;
  localparam logic [4:0] S_BT_CHK = 5'd18;

  typedef struct packed {
    logic [NB-1:0] fail;
    logic [NB-1:0] outl;
  } link_t;

  typedef struct packed {
    logic             ends;
    logic [LEN_W-1:0] len;
  } mark_t;

  logic [NB-1:0] child_mem [CHILD_DEPTH];
  link_t         link_mem  [NODE_COUNT];
  mark_t         mark_mem  [NODE_COUNT];
  logic [NB-1:0] queue_mem [NODE_COUNT];

  logic [CW-1:0] ch_raddr, ch_waddr;
  logic [NB-1:0] ch_rdata, ch_wdata;
  logic          ch_we;
  logic [NB-1:0] lk_raddr, lk_waddr;
  link_t         lk_rdata, lk_wdata;
  logic          lk_we;
  logic [NB-1:0] mk_raddr, mk_waddr;
  mark_t         mk_rdata, mk_wdata;
  logic          mk_we;
  logic [NB-1:0] q_raddr, q_waddr, q_rdata, q_wdata;
  logic          q_we;

  logic [4:0]               state, state_next;
  logic [CW-1:0]            clr_addr;
  logic [SB-1:0]            sym;
  logic [NB:0]              nodes_used;
  logic [NB-1:0]            cursor;
  logic [LEN_W-1:0]         depth;
  logic                     broken;
  logic [NB-1:0]            search_node;
  logic [POSITION_BITS-1:0] text_pos;
  logic [POSITION_BITS-1:0] match_pos;
  logic [NB-1:0]            n, t, cur, fcur, f, c, tf;
  logic [NB:0]              head, tail;
  logic [SB-1:0]            s;

  logic [SB-1:0] cmd_sym;
  logic          s_last;
  logic [NB-1:0] new_node;
  logic [NB-1:0] tf_calc;
  logic [NB-1:0] out_calc;

  assign cmd_sym  = cmd.sym[SB-1:0];
  assign s_last   = (s == SB'(ALPHABET_SIZE - 1));
  assign new_node = nodes_used[NB-1:0];
  assign tf_calc  = (ch_rdata != '0 && ch_rdata != c) ? ch_rdata : '0;
  assign out_calc = (tf == '0) ? '0 : (mk_rdata.ends ? tf : lk_rdata.outl);

  always_ff @(posedge clk) begin
    if (ch_we) child_mem[ch_waddr] <= ch_wdata;
    ch_rdata <= child_mem[ch_raddr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    lk_rdata <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_waddr] <= mk_wdata;
    mk_rdata <= mark_mem[mk_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata <= queue_mem[q_raddr];
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    ch_raddr   = '0;
    ch_we      = 1'b0;
    ch_waddr   = '0;
    ch_wdata   = '0;
    lk_raddr   = '0;
    lk_we      = 1'b0;
    lk_waddr   = '0;
    lk_wdata   = '0;
    mk_raddr   = '0;
    mk_we      = 1'b0;
    mk_waddr   = '0;
    mk_wdata   = '0;
    q_raddr    = head[NB-1:0];
    q_we       = 1'b0;
    q_waddr    = tail[NB-1:0];
    q_wdata    = '0;
    res_push   = 1'b0;
    res        = '{kind: RES_MATCH, end_index: 32'(match_pos),
                   pattern_length: mk_rdata.len, last: (lk_rdata.outl == '0)};
    unique case (state)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_addr;
        if (clr_addr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid) begin
          unique case (cmd.op)
            KIND_PAT_SYM: begin
              if (!broken) begin
                if (depth >= LEN_W'(MAX_PATTERN_LENGTH)) begin
                  state_next = S_OVF;
                end else begin
                  ch_raddr   = {cursor, cmd_sym};
                  state_next = S_PS_CHK;
                end
              end
            end
            KIND_PAT_END: begin
              if (!broken && depth != '0) begin
                mk_we    = 1'b1;
                mk_waddr = cursor;
                mk_wdata = '{ends: 1'b1, len: depth};
              end
            end
            KIND_BUILD:     state_next = S_BR_RD;
            KIND_TEXT_SYM:  state_next = S_TF_RD;
            default: ;
          endcase
        end
      end
      S_PS_CHK: begin
        if (ch_rdata != '0) begin
          state_next = S_IDLE;
        end else if (nodes_used >= (NB+1)'(NODE_COUNT)) begin
          state_next = S_OVF;
        end else begin
          ch_we      = 1'b1;
          ch_waddr   = {cursor, sym};
          ch_wdata   = new_node;
          lk_we      = 1'b1;
          lk_waddr   = new_node;
          mk_we      = 1'b1;
          mk_waddr   = new_node;
          state_next = S_IDLE;
        end
      end
      S_OVF: begin
        if (!res_full) begin
          res_push   = 1'b1;
          res        = '{kind: RES_OVERFLOW, end_index: '0,
                         pattern_length: '0, last: 1'b1};
          state_next = S_IDLE;
        end
      end
      S_TF_RD: begin
        ch_raddr   = {n, sym};
        lk_raddr   = n;
        state_next = S_TF_CHK;
      end
      S_TF_CHK: begin
        if (ch_rdata != '0 || n == '0) state_next = S_TO_RD;
        else                          state_next = S_TF_RD;
      end
      S_TO_RD: begin
        mk_raddr = t;
        lk_raddr = t;
        if (t == '0) state_next = S_IDLE;
        else         state_next = S_TO_CHK;
      end
      S_TO_CHK: begin
        mk_raddr = t;
        lk_raddr = t;
        if (mk_rdata.ends) begin
          if (!res_full) begin
            res_push   = 1'b1;
            state_next = S_TO_RD;
          end
        end else begin
          state_next = S_TO_RD;
        end
      end
      S_BR_RD: begin
        ch_raddr   = {NB'(0), s};
        state_next = S_BR_CHK;
      end
      S_BR_CHK: begin
        if (ch_rdata != '0) begin
          lk_we    = 1'b1;
          lk_waddr = ch_rdata;
          q_we     = 1'b1;
          q_wdata  = ch_rdata;
        end
        state_next = s_last ? S_BP : S_BR_RD;
      end
      S_BP: begin
        if (head == tail) state_next = S_IDLE;
        else              state_next = S_BP2;
      end
      S_BP2: begin
        lk_raddr   = q_rdata;
        state_next = S_BCUR;
      end
      S_BCUR: state_next = S_BS_RD;
      S_BS_RD: begin
        ch_raddr   = {cur, s};
        state_next = S_BS_CHK;
      end
      S_BS_CHK: begin
        if (ch_rdata != '0) begin
          q_we       = 1'b1;
          q_wdata    = ch_rdata;
          state_next = S_BF_RD;
        end else begin
          state_next = s_last ? S_BP : S_BS_RD;
        end
      end
      S_BF_RD: begin
        ch_raddr   = {f, s};
        lk_raddr   = f;
        state_next = S_BF_CHK;
      end
      S_BF_CHK: begin
        if (f != '0 && ch_rdata == '0) state_next = S_BF_RD;
        else                          state_next = S_BT_RD;
      end
      S_BT_RD: begin
        mk_raddr   = tf;
        lk_raddr   = tf;
        state_next = S_BT_CHK;
      end
      S_BT_CHK: begin
        lk_we      = 1'b1;
        lk_waddr   = c;
        lk_wdata   = '{fail: tf, outl: out_calc};
        state_next = s_last ? S_BP : S_BS_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      nodes_used  <= (NB+1)'(1);
      cursor      <= '0;
      depth       <= '0;
      broken      <= 1'b0;
      search_node <= '0;
      text_pos    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (cmd_valid) begin
            sym <= cmd_sym;
            s   <= '0;
            unique case (cmd.op)
              KIND_PAT_SYM: begin
                if (!broken && depth >= LEN_W'(MAX_PATTERN_LENGTH)) broken <= 1'b1;
              end
              KIND_PAT_END: begin
                cursor <= '0;
                depth  <= '0;
                broken <= 1'b0;
              end
              KIND_BUILD: begin
                head <= '0;
                tail <= '0;
              end
              KIND_TEXT_SYM: n <= search_node;
              KIND_TEXT_START: begin
                search_node <= '0;
                text_pos    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_PS_CHK: begin
          if (ch_rdata != '0) begin
            cursor <= ch_rdata;
            depth  <= depth + 1'b1;
          end else if (nodes_used >= (NB+1)'(NODE_COUNT)) begin
            broken <= 1'b1;
          end else begin
            cursor     <= new_node;
            nodes_used <= nodes_used + 1'b1;
            depth      <= depth + 1'b1;
          end
        end
        S_TF_CHK: begin
          if (ch_rdata != '0 || n == '0) begin
            search_node <= (ch_rdata != '0) ? ch_rdata : '0;
            t           <= (ch_rdata != '0) ? ch_rdata : '0;
            match_pos   <= text_pos;
            text_pos    <= text_pos + 1'b1;
          end else begin
            n <= lk_rdata.fail;
          end
        end
        S_TO_CHK: begin
          if (!mk_rdata.ends || !res_full) t <= lk_rdata.outl;
        end
        S_BR_CHK: begin
          if (ch_rdata != '0) tail <= tail + 1'b1;
          s <= s + 1'b1;
        end
        S_BP2: begin
          cur  <= q_rdata;
          head <= head + 1'b1;
        end
        S_BCUR: begin
          fcur <= lk_rdata.fail;
          s    <= '0;
        end
        S_BS_CHK: begin
          if (ch_rdata != '0) begin
            tail <= tail + 1'b1;
            c    <= ch_rdata;
            f    <= fcur;
          end else begin
            s <= s + 1'b1;
          end
        end
        S_BF_CHK: begin
          if (f != '0 && ch_rdata == '0) f <= lk_rdata.fail;
          else                          tf <= tf_calc;
        end
        S_BT_CHK: s <= s + 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### hdl/mpsm_result_fifo.sv
// ----------------------------------------------------------------------------
// mpsm_result_fifo
// Small result queue that decouples the engine from the receiver.
// ----------------------------------------------------------------------------
module mpsm_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  output logic              wr_full,
  input  mpsm_pkg::result_t wr_data,
  output logic              empty,
  input  logic              pop,
  output mpsm_pkg::result_t rd_data
);
  import mpsm_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  result_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          enq;
  logic          deq;

  assign wr_full = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];
  assign enq     = wr && !wr_full;
  assign deq     = pop && !empty;

  always_ff @(posedge clk) begin
    if (enq) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(enq) - (PW+1)'(deq);
    end
  end

endmodule

### hdl/multi_pattern_string_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick matcher over byte symbols with queue-style channels.
// ----------------------------------------------------------------------------
// Input beats are written with push while full is low; each carries a kind
// (pattern symbol, pattern end, build links, text symbol, text start) and a
// symbol. Results are read with pop while empty is low; each text symbol gives
// one beat per pattern ending there, the final one flagged by last_of_run, and
// an overflowing pattern gives a single beat with result_kind set.
// A four-entry command queue feeds the sequencer and a four-entry result queue
// follows it, so either side may stall without stopping the other.
// A text symbol follows failure links and then the output chain, limited by the
// single read port of the child table; a build visits every alphabet symbol of
// the root and of every node, each child edge and each failure link step. After
// reset the child table, 2^(clog2(NODE_COUNT)+clog2(ALPHABET_SIZE)) entries
// (65536 by default), is cleared one entry a cycle; beats are queued meanwhile
// but not processed. A stalled receiver backs the engine up once the result
// queue is full, then the command queue fills.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
  parameter int NODE_COUNT         = 256,
  parameter int ALPHABET_SIZE      = 256,
  parameter int MAX_PATTERN_LENGTH = 64,
  parameter int POSITION_BITS      = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mpsm_pkg::KIND_W-1:0] kind,
  input  logic [mpsm_pkg::SYM_W-1:0]  symbol,
  output logic                        empty,
  input  logic                        pop,
  output logic                        result_kind,
  output logic [mpsm_pkg::POS_W-1:0]  end_index,
  output logic [mpsm_pkg::LEN_W-1:0]  pattern_length,
  output logic                        last_of_run
);
  import mpsm_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_pop;
  result_t res;
  logic    res_push;
  logic    res_full;
  result_t head_res;

  mpsm_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .symbol    (symbol),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  mpsm_engine #(
    .NODE_COUNT         (NODE_COUNT),
    .ALPHABET_SIZE      (ALPHABET_SIZE),
    .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH),
    .POSITION_BITS      (POSITION_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mpsm_result_fifo u_results (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_full (res_full),
    .wr_data (res),
    .empty   (empty),
    .pop     (pop),
    .rd_data (head_res)
  );

  assign result_kind    = head_res.kind;
  assign end_index      = head_res.end_index;
  assign pattern_length = head_res.pattern_length;
  assign last_of_run    = head_res.last;

endmodule

### hdl/mpsm_checker.sv
// ----------------------------------------------------------------------------
// mpsm_checker
// Port-level checks of the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mpsm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input logic                        result_kind,
  input logic [mpsm_pkg::POS_W-1:0]  end_index,
  input logic [mpsm_pkg::LEN_W-1:0]  pattern_length,
  input logic                        last_of_run
);
  import mpsm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_overflow_beat: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == RES_OVERFLOW) |->
      (pattern_length == '0 && end_index == '0 && last_of_run))
    else $error("overflow beat carries a length, position or no last flag");

  a_match_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == RES_MATCH) |-> (pattern_length != '0))
    else $error("match beat with zero pattern length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(result_kind) && $stable(end_index) &&
       $stable(pattern_length) && $stable(last_of_run)))
    else $error("waiting result changed while stalled");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-pattern string matcher testbench
// Loads pattern sets into the matcher, builds its links and streams text
// through it, predicting every match and overflow beat with a behavioural
// automaton kept alongside, and compares each popped beat with the oldest
// predicted one while both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import mpsm_pkg::*;

  localparam int NODES    = 256;
  localparam int MAX_LEN  = 64;
  localparam int ROOT     = 0;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [KIND_W-1:0]   kind;
  logic [SYM_W-1:0]    symbol;
  logic                empty;
  logic                pop;
  logic                result_kind;
  logic [POS_W-1:0]    end_index;
  logic [LEN_W-1:0]    pattern_length;
  logic                last_of_run;

  multi_pattern_string_matcher DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .symbol(symbol), .empty(empty), .pop(pop), .result_kind(result_kind),
    .end_index(end_index), .pattern_length(pattern_length),
    .last_of_run(last_of_run)
  );

  int          trie_child [int];
  int          fail_of [NODES];
  int          out_of [NODES];
  bit          is_end [NODES];
  logic [6:0]  len_of [NODES];
  int          used_nodes;
  int          cursor;
  int          depth;
  bit          broken;
  int          walk_node;
  logic [31:0] text_pos;

  result_t     pending_beats [$];
  int          errors;
  bit          idle_on;
  bit          stall_rx;

  function automatic int child_of(int n, int s);
    int key;
    key = n * 256 + s;
    if (trie_child.exists(key)) return trie_child[key];
    return ROOT;
  endfunction

  function automatic result_t make_beat(logic k, logic [31:0] p, logic [6:0] l, logic t);
    result_t r;
    r.kind = k;
    r.end_index = p;
    r.pattern_length = l;
    r.last = t;
    return r;
  endfunction

  task automatic rebuild_links();
    int order [$];
    int cur, c, f, g, t, steps;
    fail_of[ROOT] = ROOT;
    out_of[ROOT] = ROOT;
    for (int s = 0; s < 256; s++) begin
      c = child_of(ROOT, s);
      if (c != ROOT) begin
        fail_of[c] = ROOT;
        out_of[c] = ROOT;
        order = {order, c};
      end
    end
    while (order.size() > 0) begin
      cur = order.pop_front();
      for (int s = 0; s < 256; s++) begin
        c = child_of(cur, s);
        if (c != ROOT) begin
          order = {order, c};
          f = fail_of[cur];
          steps = 0;
          while (f != ROOT && child_of(f, s) == ROOT && steps < NODES) begin
            f = fail_of[f];
            steps++;
          end
          if (steps >= NODES) f = ROOT;
          g = child_of(f, s);
          fail_of[c] = (g != ROOT && g != c) ? g : ROOT;
          t = fail_of[c];
          out_of[c] = is_end[t] ? t : out_of[t];
        end
      end
    end
  endtask

  task automatic predict_beat(logic [2:0] k, logic [7:0] s);
    int c, n, g, t, steps, count;
    logic [31:0] p;
    case (k)
      KIND_PAT_SYM: begin
        if (broken) return;
        c = child_of(cursor, int'(s));
        if (depth >= MAX_LEN || (c == ROOT && used_nodes >= NODES)) begin
          broken = 1;
          pending_beats = {pending_beats, make_beat(RES_OVERFLOW, '0, '0, 1'b1)};
          return;
        end
        if (c == ROOT) begin
          c = used_nodes++;
          fail_of[c] = ROOT;
          out_of[c] = ROOT;
          is_end[c] = 0;
          len_of[c] = '0;
          trie_child[cursor * 256 + int'(s)] = c;
        end
        cursor = c;
        depth++;
      end
      KIND_PAT_END: begin
        if (!broken && depth > 0) begin
          is_end[cursor] = 1;
          len_of[cursor] = depth[6:0];
        end
        cursor = ROOT;
        depth = 0;
        broken = 0;
      end
      KIND_BUILD: rebuild_links();
      KIND_TEXT_SYM: begin
        n = walk_node;
        steps = 0;
        p = text_pos;
        while (n != ROOT && child_of(n, int'(s)) == ROOT && steps < NODES) begin
          n = fail_of[n];
          steps++;
        end
        if (steps >= NODES) n = ROOT;
        g = child_of(n, int'(s));
        if (g != ROOT) n = g;
        walk_node = n;
        text_pos = text_pos + 32'd1;
        t = n;
        steps = 0;
        count = 0;
        while (t != ROOT && count < 64 && steps < NODES) begin
          if (is_end[t]) begin
            pending_beats = {pending_beats, make_beat(RES_MATCH, p, len_of[t], 1'b0)};
            count++;
          end
          t = out_of[t];
          steps++;
        end
        if (count > 0) pending_beats[$].last = 1'b1;
      end
      KIND_TEXT_START: begin
        walk_node = ROOT;
        text_pos = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(logic [2:0] k, logic [7:0] s);
    if (idle_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 8)) @(negedge clk);
    push = 1'b1;
    kind = k;
    symbol = s;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_beat(k, s);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0) @(negedge clk);
    repeat (4000) @(negedge clk);
  endtask

  task automatic send_pattern(int n, int base, int span);
    for (int i = 0; i < n; i++) send_beat(KIND_PAT_SYM, 8'(base + $urandom_range(0, span)));
    send_beat(KIND_PAT_END, 8'($urandom));
  endtask

  task automatic test_directed();
    send_beat(KIND_PAT_END, 8'hFF);
    send_beat(KIND_PAT_SYM, 8'h00);
    send_beat(KIND_PAT_END, 8'h00);
    send_beat(KIND_PAT_SYM, 8'hFF);
    send_beat(KIND_PAT_SYM, 8'h00);
    send_beat(KIND_PAT_END, 8'h00);
    send_beat(KIND_PAT_SYM, 8'h00);
    send_beat(KIND_PAT_END, 8'h00);
    send_beat(KIND_BUILD, 8'hAA);
    send_beat(KIND_TEXT_SYM, 8'hFF);
    send_beat(KIND_TEXT_SYM, 8'h00);
    send_beat(KIND_TEXT_SYM, 8'h00);
    send_beat(3'd5, 8'h55);
    send_beat(3'd7, 8'hFF);
    send_beat(KIND_TEXT_START, 8'h12);
    send_beat(KIND_TEXT_SYM, 8'h00);
    send_beat(KIND_PAT_SYM, 8'h5A);
    send_beat(KIND_PAT_END, 8'h00);
    send_beat(KIND_TEXT_SYM, 8'h5A);
    wait_drained();
  endtask

  task automatic test_long_pattern();
    for (int i = 0; i < MAX_LEN + 2; i++) send_beat(KIND_PAT_SYM, 8'h41);
    send_beat(KIND_PAT_END, 8'h00);
    send_beat(KIND_BUILD, 8'h00);
    send_beat(KIND_TEXT_START, 8'h00);
    for (int i = 0; i < 4; i++) send_beat(KIND_TEXT_SYM, 8'h41);
    wait_drained();
  endtask

  task automatic test_random_text();
    int draw;
    idle_on = 1;
    for (int p = 0; p < 6; p++) send_pattern($urandom_range(1, 4), 8'h61, 3);
    send_beat(KIND_BUILD, 8'h00);
    for (int i = 0; i < 90; i++) begin
      draw = $urandom_range(0, 99);
      if (i == 45) wait_drained();
      if (i == 75) idle_on = 0;
      if (draw < 82) send_beat(KIND_TEXT_SYM, 8'(8'h61 + $urandom_range(0, 3)));
      else if (draw < 88) send_beat(KIND_TEXT_SYM, 8'($urandom));
      else if (draw < 92) send_beat(KIND_TEXT_START, 8'($urandom));
      else if (draw < 96) send_beat(3'($urandom_range(5, 7)), 8'($urandom));
      else send_pattern(1, 8'h61, 3);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat kind=%0d pos=%0d len=%0d", result_kind, end_index,
               pattern_length);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind expected %0d actual %0d", want.kind, result_kind);
          errors++;
        end
        if (end_index !== want.end_index) begin
          $error("end_index expected %0d actual %0d", want.end_index, end_index);
          errors++;
        end
        if (pattern_length !== want.pattern_length) begin
          $error("pattern_length expected %0d actual %0d", want.pattern_length,
                 pattern_length);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run expected %0d actual %0d", want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!idle_on) begin
      stall_rx <= 1'b0;
      pop <= 1'b1;
    end else if (stall_rx) begin
      if ($urandom_range(0, 7) == 0) stall_rx <= 1'b0;
      pop <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_rx <= 1'b1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    kind = '0;
    symbol = '0;
    stall_rx = 1'b0;
    idle_on = 1'b1;
    errors = 0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = 0;
      out_of[i] = 0;
      is_end[i] = 0;
      len_of[i] = '0;
    end
    used_nodes = 1;
    cursor = ROOT;
    depth = 0;
    broken = 0;
    walk_node = ROOT;
    text_pos = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_long_pattern();
    test_random_text();
    wait_drained();
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
